[hdl/two_class_order_queue_core_macros.svh]
// Assertion macros shared by the two-class order queue RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef TWO_CLASS_ORDER_QUEUE_CORE_MACROS_SVH
`define TWO_CLASS_ORDER_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCOQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCOQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/tcoq_pkg.sv]
// Shared types and constants of the two-class order queue.
// Depends on nothing; used by the issue sequencer, the top level and the testbench.
package tcoq_pkg;

	localparam int ORDER_DEPTH = 64;
	localparam int ORDER_AW    = 6;
	localparam int ORDER_CW    = 7;

	typedef enum logic [2:0] {
		ACT_ADD       = 3'd0,
		ACT_POLL      = 3'd1,
		ACT_DRAIN_DOG = 3'd2,
		ACT_DRAIN_CAT = 3'd3,
		ACT_QUERY     = 3'd4
	} action_t;

	localparam logic KIND_DOG = 1'b0;
	localparam logic KIND_CAT = 1'b1;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} seq_state_t;

	// Start request from the command decoder to the issue sequencer.
	typedef struct packed {
		logic                load;
		logic [ORDER_CW-1:0] cnt;
		logic                cls_only;
		logic                cls;
	} run_req_t;

	// One issue slot per cycle while a poll or drain runs.
	typedef struct packed {
		logic valid;
		logic last;
		logic cls_only;
		logic cls;
	} issue_t;

endpackage

[hdl/tcoq_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module tcoq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/tcoq_issue.sv]
// Issue sequencer: hands out one pop slot per cycle for a poll or a drain.
// Depends on tcoq_pkg.
module tcoq_issue (
	input  logic              clk,
	input  logic              arst_n,
	input  tcoq_pkg::run_req_t req,
	output tcoq_pkg::issue_t  iss,
	output logic              running
);
	import tcoq_pkg::*;

	seq_state_t          state_q, state_d;
	logic [ORDER_CW-1:0] rem_q;
	logic                cls_only_q;
	logic                cls_q;
	logic                at_last;

	assign at_last = (rem_q == ORDER_CW'(1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.load) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (at_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		iss.valid    = 1'b0;
		iss.last     = 1'b0;
		iss.cls_only = cls_only_q;
		iss.cls      = cls_q;
		running      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				running = 1'b0;
			end
			ST_RUN: begin
				iss.valid = 1'b1;
				iss.last  = at_last;
				running   = 1'b1;
			end
			default: running = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rem_q      <= '0;
			cls_only_q <= 1'b0;
			cls_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && req.load) begin
				rem_q      <= req.cnt;
				cls_only_q <= req.cls_only;
				cls_q      <= req.cls;
			end else if (state_q == ST_RUN) begin
				rem_q <= rem_q - ORDER_CW'(1);
			end
		end
	end

endmodule

[hdl/two_class_order_queue_core.sv]
// Top level of the two-class order queue: command decode, pointers and pop pipeline.
// Depends on tcoq_pkg, tcoq_ram, tcoq_issue and the assertion macro header.
//
// Usage: an item is taken at a rising edge with start high and busy low. Results
// leave on strobe, one per cycle, and the receiver cannot stall them, so any
// consumer must be able to take a result in every cycle. An add that fits gives
// no result and leaves busy low, so adds may follow back to back. A query, or an
// add whose class is full, gives one status result in the cycle after it is
// taken, also without raising busy. A poll-all or a drain that has entries to
// emit raises busy until its last result has left, then admits the next item;
// the results follow one per cycle, and the lead comes from the chained
// synchronous memory reads, the arrival-order tag first and the class value after
// it; a drain reads no tag but passes through the same stage. A poll or a
// drain that finds nothing to emit, and an unused action code, give no result.
// There is no clearing pass after reset: the class stores and the tag store are
// only read where they were written before.
module two_class_order_queue_core #(
	parameter int CLASS_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  logic        kind,
	input  logic signed [31:0] value,
	output logic        strobe,
	output logic        kind_res,
	output logic signed [31:0] value_res,
	output logic        is_status,
	output logic        all_empty,
	output logic        dogs_empty,
	output logic        cats_empty,
	output logic        overflow,
	output logic        last
);
	import tcoq_pkg::*;

`include "two_class_order_queue_core_macros.svh"

	// Index width of one class ring, count width, and the joint value memory
	// address, which is the class bit on top of the ring index.
	localparam int CW     = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
	localparam int CNT_W  = $clog2(CLASS_DEPTH + 1);
	localparam int VAW    = CW + 1;
	localparam int VDEPTH = 2 ** VAW;

	action_t act;
	logic    acc;

	// Class ring pointers and counts.
	logic [CW-1:0]    dog_head_q, cat_head_q;
	logic [CNT_W-1:0] dog_cnt_q, cat_cnt_q;

	// Arrival-order ring. After a drain the surviving entries are all of one
	// class, so instead of rewriting their tags the first uni_len_q slots of the
	// ring read as uni_kind_q until the next poll-all consumes them.
	logic [ORDER_AW-1:0] order_head_q;
	logic [ORDER_CW-1:0] order_cnt_q;
	logic [ORDER_CW-1:0] uni_len_q;
	logic                uni_kind_q;

	// Status result register.
	logic stat_q, stat_all_q, stat_dog_q, stat_cat_q, stat_ovf_q;

	// Pop pipeline: stage 1 holds the tag read, stage 2 the value read.
	logic v_s1, last_s1, cls_only_s1, cls_s1, uni_s1, ukind_s1;
	logic v_s2, last_s2, kind_s2;

	// Add decode.
	logic [CW-1:0]       sel_head;
	logic [CNT_W-1:0]    sel_cnt;
	logic                add_full;
	logic [VAW-1:0]      wsum;
	logic [VAW-1:0]      windex;
	logic [VAW-1:0]      vwaddr;
	logic [ORDER_AW-1:0] tag_waddr;
	logic                do_add;
	logic                stat_d;

	run_req_t req;
	issue_t   iss;
	logic     running;

	// Pop side.
	logic           tag_re;
	logic [0:0]     tag_rdata;
	logic           uni_s0;
	logic           kind1;
	logic [CW-1:0]  pop_head;
	logic [CW-1:0]  pop_head_nxt;
	logic [VAW-1:0] vraddr;
	logic [31:0]    vrdata;

	assign act = action_t'(action);
	assign acc = start && !busy;

	// The memories are never written while a poll or drain is in flight, so a
	// read never meets a write to the same entry; busy is the interlock.
	assign busy = running || v_s1 || v_s2;

	assign sel_head  = kind ? cat_head_q : dog_head_q;
	assign sel_cnt   = kind ? cat_cnt_q : dog_cnt_q;
	assign add_full  = (sel_cnt == CNT_W'(CLASS_DEPTH)) ||
		(order_cnt_q == ORDER_CW'(ORDER_DEPTH));
	// Head plus count stays below twice the depth, so one subtract wraps it.
	assign wsum      = VAW'(sel_head) + VAW'(sel_cnt);
	assign windex    = (wsum >= VAW'(CLASS_DEPTH)) ? (wsum - VAW'(CLASS_DEPTH)) : wsum;
	assign vwaddr    = {kind, windex[CW-1:0]};
	assign tag_waddr = order_head_q + order_cnt_q[ORDER_AW-1:0];
	assign do_add    = acc && (act == ACT_ADD) && !add_full;
	assign stat_d    = acc && ((act == ACT_QUERY) || ((act == ACT_ADD) && add_full));

	// Start a poll or a drain only when it has something to emit.
	always_comb begin
		req.load     = 1'b0;
		req.cnt      = order_cnt_q;
		req.cls_only = 1'b0;
		req.cls      = KIND_DOG;
		unique case (act)
			ACT_POLL: begin
				req.load = acc && (order_cnt_q != '0);
			end
			ACT_DRAIN_DOG: begin
				req.load     = acc && (dog_cnt_q != '0);
				req.cnt      = ORDER_CW'(dog_cnt_q);
				req.cls_only = 1'b1;
				req.cls      = KIND_DOG;
			end
			ACT_DRAIN_CAT: begin
				req.load     = acc && (cat_cnt_q != '0);
				req.cnt      = ORDER_CW'(cat_cnt_q);
				req.cls_only = 1'b1;
				req.cls      = KIND_CAT;
			end
			default: req.load = 1'b0;
		endcase
	end

	tcoq_issue u_issue (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.iss     (iss),
		.running (running)
	);

	// Stage 0: a poll reads the tag at the order head; a drain needs no tag.
	assign tag_re = iss.valid && !iss.cls_only;
	assign uni_s0 = (ORDER_CW'(order_head_q) < uni_len_q);

	tcoq_ram #(
		.WIDTH (1),
		.DEPTH (ORDER_DEPTH)
	) u_tag_ram (
		.clk   (clk),
		.we    (do_add),
		.waddr (tag_waddr),
		.wdata (kind),
		.re    (tag_re),
		.raddr (order_head_q),
		.rdata (tag_rdata)
	);

	// Stage 1: resolve the class and pop its head from the value memory.
	assign kind1        = cls_only_s1 ? cls_s1 : (uni_s1 ? ukind_s1 : tag_rdata[0]);
	assign pop_head     = kind1 ? cat_head_q : dog_head_q;
	assign pop_head_nxt = (pop_head == CW'(CLASS_DEPTH - 1)) ? '0 : (pop_head + CW'(1));
	assign vraddr       = {kind1, pop_head};

	tcoq_ram #(
		.WIDTH (32),
		.DEPTH (VDEPTH)
	) u_value_ram (
		.clk   (clk),
		.we    (do_add),
		.waddr (vwaddr),
		.wdata (value),
		.re    (v_s1),
		.raddr (vraddr),
		.rdata (vrdata)
	);

	// Order ring bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_head_q <= '0;
			order_cnt_q  <= '0;
			uni_len_q    <= '0;
			uni_kind_q   <= KIND_DOG;
		end else if (acc) begin
			unique case (act)
				ACT_ADD: begin
					if (!add_full) begin
						order_cnt_q <= order_cnt_q + ORDER_CW'(1);
					end
				end
				ACT_POLL: begin
					order_cnt_q <= '0;
				end
				ACT_DRAIN_DOG: begin
					if (dog_cnt_q != '0) begin
						order_head_q <= '0;
						order_cnt_q  <= ORDER_CW'(cat_cnt_q);
						uni_len_q    <= ORDER_CW'(cat_cnt_q);
						uni_kind_q   <= KIND_CAT;
					end
				end
				ACT_DRAIN_CAT: begin
					if (cat_cnt_q != '0) begin
						order_head_q <= '0;
						order_cnt_q  <= ORDER_CW'(dog_cnt_q);
						uni_len_q    <= ORDER_CW'(dog_cnt_q);
						uni_kind_q   <= KIND_DOG;
					end
				end
				default: begin
					order_cnt_q <= order_cnt_q;
				end
			endcase
		end else if (tag_re) begin
			order_head_q <= order_head_q + ORDER_AW'(1);
			// The uniform region is used up once the poll has read its last tag.
			if (iss.last) begin
				uni_len_q <= '0;
			end
		end
	end

	// Class rings: an add appends, a stage 1 pop advances the head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dog_head_q <= '0;
			cat_head_q <= '0;
			dog_cnt_q  <= '0;
			cat_cnt_q  <= '0;
		end else if (do_add) begin
			if (kind == KIND_CAT) begin
				cat_cnt_q <= cat_cnt_q + CNT_W'(1);
			end else begin
				dog_cnt_q <= dog_cnt_q + CNT_W'(1);
			end
		end else if (v_s1) begin
			if (kind1 == KIND_CAT) begin
				cat_head_q <= pop_head_nxt;
				cat_cnt_q  <= cat_cnt_q - CNT_W'(1);
			end else begin
				dog_head_q <= pop_head_nxt;
				dog_cnt_q  <= dog_cnt_q - CNT_W'(1);
			end
		end
	end

	// Pipeline valid bits and status strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			stat_q <= 1'b0;
		end else begin
			v_s1   <= iss.valid;
			v_s2   <= v_s1;
			stat_q <= stat_d;
		end
	end

	// Pipeline and status payload.
	always_ff @(posedge clk) begin
		last_s1     <= iss.last;
		cls_only_s1 <= iss.cls_only;
		cls_s1      <= iss.cls;
		uni_s1      <= uni_s0;
		ukind_s1    <= uni_kind_q;
		last_s2     <= last_s1;
		kind_s2     <= kind1;
		// Query and overflow leave the state as it is, so the flags are current.
		stat_all_q  <= (order_cnt_q == '0);
		stat_dog_q  <= (dog_cnt_q == '0);
		stat_cat_q  <= (cat_cnt_q == '0);
		stat_ovf_q  <= (act == ACT_ADD);
	end

	// Entry results and status results never share a cycle, since busy keeps
	// a status item out while the pop pipeline holds anything.
	assign strobe     = v_s2 || stat_q;
	assign kind_res   = v_s2 && kind_s2;
	assign value_res  = v_s2 ? signed'(vrdata) : '0;
	assign is_status  = !v_s2 && stat_q;
	assign all_empty  = !v_s2 && stat_q && stat_all_q;
	assign dogs_empty = !v_s2 && stat_q && stat_dog_q;
	assign cats_empty = !v_s2 && stat_q && stat_cat_q;
	assign overflow   = !v_s2 && stat_q && stat_ovf_q;
	assign last       = v_s2 ? last_s2 : stat_q;

	`TCOQ_ASSERT_IMP(a_one_result_source, clk, arst_n, v_s2, !stat_q, "entry and status results overlap")
	`TCOQ_ASSERT_IMP(a_order_matches_classes, clk, arst_n, !busy, order_cnt_q == (ORDER_CW'(dog_cnt_q) + ORDER_CW'(cat_cnt_q)), "order count differs from class counts")
	`TCOQ_ASSERT_NXT(a_last_ends_burst, clk, arst_n, v_s2 && last_s2, !v_s2, "pop result after the last one")
	`TCOQ_ASSERT_IMP(a_no_dog_underflow, clk, arst_n, v_s1 && (kind1 == KIND_DOG), dog_cnt_q != '0, "pop from empty dog ring")
	`TCOQ_ASSERT_IMP(a_no_cat_underflow, clk, arst_n, v_s1 && (kind1 == KIND_CAT), cat_cnt_q != '0, "pop from empty cat ring")

endmodule

[sim/two_class_order_queue_core_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench of two_class_order_queue_core: directed items, then random
// command sequences. Depends on tcoq_pkg and the core RTL only.
module two_class_order_queue_core_test;

	import tcoq_pkg::*;

	localparam int CLASS_DEPTH = 32;

	// Action codes the core leaves unused; they must be ignored without a result.
	localparam logic [2:0] ACT_SPARE_LO = 3'd5;
	localparam logic [2:0] ACT_SPARE_HI = 3'd7;

	// Per-cycle chance, in percent, that the sender holds back the next item.
	localparam int CALM_IDLE_PCT = 8;
	localparam int HEAVY_IDLE_PCT = 67;
	localparam int MAX_GAP = 20;

	localparam int USEFUL_ITEMS = 300;
	localparam int DRAIN_OUT_CYCLES = 8;
	localparam int RUN_LIMIT_NS = 2_000_000;

	// One command for the core, with the idle cycles the sender waits after the
	// previous item was taken.
	typedef struct {
		logic [2:0]         action;
		logic               kind;
		logic signed [31:0] value;
		int unsigned        gap;
	} cmd_t;

	// One result as the core should present it.
	typedef struct {
		logic               kind_res;
		logic signed [31:0] value_res;
		logic               is_status;
		logic               all_empty;
		logic               dogs_empty;
		logic               cats_empty;
		logic               overflow;
		logic               last;
	} out_rec_t;

	logic clk;
	logic arst_n = 1'b0;

	logic               start = 1'b0;
	logic               busy;
	logic [2:0]         action = ACT_QUERY;
	logic               kind = KIND_DOG;
	logic signed [31:0] value = '0;
	logic               strobe;
	logic               kind_res;
	logic signed [31:0] value_res;
	logic               is_status;
	logic               all_empty;
	logic               dogs_empty;
	logic               cats_empty;
	logic               overflow;
	logic               last;

	two_class_order_queue_core #(
		.CLASS_DEPTH(CLASS_DEPTH)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.action    (action),
		.kind      (kind),
		.value     (value),
		.strobe    (strobe),
		.kind_res  (kind_res),
		.value_res (value_res),
		.is_status (is_status),
		.all_empty (all_empty),
		.dogs_empty(dogs_empty),
		.cats_empty(cats_empty),
		.overflow  (overflow),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Commands still to be sent, and how many queued commands were not ignored codes.
	cmd_t        cmd_backlog[$];
	int unsigned useful_cmds = 0;
	int unsigned cmd_total = 0;
	int unsigned cmds_taken = 0;
	int unsigned mismatches = 0;

	// Shadow of the core: one FIFO per class, and the class tags in arrival order.
	// The tag FIFO always holds one tag per stored entry, so its size is the
	// order count of the core.
	logic signed [31:0] dog_line[$];
	logic signed [31:0] cat_line[$];
	logic               arrival_tags[$];

	// Results predicted but not yet seen, oldest first.
	out_rec_t awaited_out[$];

	function automatic out_rec_t entry_rec(input logic k, input logic signed [31:0] v);
		out_rec_t r;
		r = '{default: '0};
		r.kind_res = k;
		r.value_res = v;
		return r;
	endfunction

	// Status answers report the empty flags as they stand after the command.
	function automatic out_rec_t status_rec(input logic ovf);
		out_rec_t r;
		r = '{default: '0};
		r.is_status = 1'b1;
		r.all_empty = (arrival_tags.size() == 0);
		r.dogs_empty = (dog_line.size() == 0);
		r.cats_empty = (cat_line.size() == 0);
		r.overflow = ovf;
		return r;
	endfunction

	// Applies one taken command to the shadow and queues the results it causes.
	task automatic step_shadow_queue(input cmd_t c);
		out_rec_t batch[$];
		logic     tag;
		int       class_fill;
		class_fill = (c.kind == KIND_DOG) ? dog_line.size() : cat_line.size();
		case (c.action)
			ACT_ADD: begin
				// A full class, or a full arrival order, drops the entry and its tag and
				// answers with an overflow status instead.
				if (class_fill >= CLASS_DEPTH || arrival_tags.size() >= ORDER_DEPTH) begin
					batch.push_back(status_rec(1'b1));
				end else begin
					if (c.kind == KIND_DOG)
						dog_line.push_back(c.value);
					else
						cat_line.push_back(c.value);
					arrival_tags.push_back(c.kind);
				end
			end
			ACT_POLL: begin
				// Walk the arrival order; a tag with no entry behind it is dropped.
				while (arrival_tags.size() != 0) begin
					tag = arrival_tags.pop_front();
					if (tag == KIND_DOG && dog_line.size() != 0)
						batch.push_back(entry_rec(KIND_DOG, dog_line.pop_front()));
					else if (tag == KIND_CAT && cat_line.size() != 0)
						batch.push_back(entry_rec(KIND_CAT, cat_line.pop_front()));
				end
			end
			ACT_DRAIN_DOG: begin
				// After a drain only the other class is left in the arrival order.
				if (dog_line.size() != 0) begin
					while (dog_line.size() != 0)
						batch.push_back(entry_rec(KIND_DOG, dog_line.pop_front()));
					arrival_tags.delete();
					repeat (cat_line.size()) arrival_tags.push_back(KIND_CAT);
				end
			end
			ACT_DRAIN_CAT: begin
				if (cat_line.size() != 0) begin
					while (cat_line.size() != 0)
						batch.push_back(entry_rec(KIND_CAT, cat_line.pop_front()));
					arrival_tags.delete();
					repeat (dog_line.size()) arrival_tags.push_back(KIND_DOG);
				end
			end
			ACT_QUERY: begin
				batch.push_back(status_rec(1'b0));
			end
			default: begin
				// Unused codes leave everything as it is.
			end
		endcase
		if (batch.size() != 0)
			batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i])
			awaited_out.push_back(batch[i]);
	endtask

	task automatic queue_cmd(input logic [2:0] act, input logic k, input logic signed [31:0] v);
		cmd_t c;
		c.action = act;
		c.kind = k;
		c.value = v;
		c.gap = 0;
		cmd_backlog.push_back(c);
		if (act <= ACT_QUERY)
			useful_cmds++;
	endtask

	// Mixes the extremes of the value range in with uniformly random values.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(7))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatches++;
		end
	endtask

	// Builds the whole command list: a directed opening, then random sequences,
	// then the idle pattern per third of the run.
	initial begin
		logic k;
		int   pct;

		// Empty core: status with all flags set, then a poll and both drains that
		// must produce nothing.
		queue_cmd(ACT_QUERY, KIND_DOG, '0);
		queue_cmd(ACT_POLL, KIND_DOG, '0);
		queue_cmd(ACT_DRAIN_DOG, KIND_DOG, '0);
		queue_cmd(ACT_DRAIN_CAT, KIND_CAT, '0);
		// Interleaved adds with the value extremes, then a query and a full poll in arrival order.
		queue_cmd(ACT_ADD, KIND_DOG, 32'sh7fff_ffff);
		queue_cmd(ACT_ADD, KIND_CAT, 32'sh8000_0000);
		queue_cmd(ACT_ADD, KIND_DOG, '0);
		queue_cmd(ACT_ADD, KIND_CAT, -32'sd1);
		queue_cmd(ACT_QUERY, KIND_CAT, '0);
		queue_cmd(ACT_POLL, KIND_DOG, '0);
		// Draining the dogs must leave the cats in their own order.
		queue_cmd(ACT_ADD, KIND_DOG, 32'sd1);
		queue_cmd(ACT_ADD, KIND_CAT, 32'sd2);
		queue_cmd(ACT_ADD, KIND_DOG, 32'sd3);
		queue_cmd(ACT_ADD, KIND_CAT, 32'sd4);
		queue_cmd(ACT_DRAIN_DOG, KIND_DOG, '0);
		queue_cmd(ACT_QUERY, KIND_DOG, '0);
		queue_cmd(ACT_ADD, KIND_DOG, 32'sd5);
		queue_cmd(ACT_POLL, KIND_CAT, '0);
		// Draining the cats, ignored codes in between, and a poll of what is left.
		queue_cmd(ACT_ADD, KIND_CAT, 32'sd6);
		queue_cmd(ACT_ADD, KIND_DOG, 32'sd7);
		queue_cmd(ACT_DRAIN_CAT, KIND_CAT, '0);
		queue_cmd(ACT_SPARE_LO, KIND_CAT, 32'sh8000_0000);
		queue_cmd(ACT_SPARE_HI, KIND_DOG, 32'sh7fff_ffff);
		queue_cmd(ACT_POLL, KIND_DOG, '0);

		// Random part: mostly bursts of adds followed by something that empties
		// the core, with fills past capacity now and then and some noise.
		while (useful_cmds < USEFUL_ITEMS) begin
			case ($urandom_range(24))
				0, 1, 2, 3, 4, 5: begin
					repeat ($urandom_range(8, 1))
						queue_cmd(ACT_ADD, 1'($urandom_range(1)), pick_value());
				end
				6, 7: queue_cmd(ACT_POLL, 1'($urandom_range(1)), pick_value());
				8: queue_cmd(ACT_DRAIN_DOG, 1'($urandom_range(1)), pick_value());
				9: queue_cmd(ACT_DRAIN_CAT, 1'($urandom_range(1)), pick_value());
				10, 11: queue_cmd(ACT_QUERY, 1'($urandom_range(1)), pick_value());
				12: begin
					// Run one class past full so the last adds overflow, then
					// look at it or empty it.
					k = 1'($urandom_range(1));
					repeat (CLASS_DEPTH + $urandom_range(3, 1)) queue_cmd(ACT_ADD, k, pick_value());
					case ($urandom_range(2))
						0: queue_cmd(ACT_QUERY, k, '0);
						1: queue_cmd(ACT_POLL, k, '0);
						default: queue_cmd((k == KIND_DOG) ? ACT_DRAIN_DOG : ACT_DRAIN_CAT, k, '0);
					endcase
				end
				13: queue_cmd(3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO)),
					1'($urandom_range(1)), $urandom);
				14: queue_cmd(3'($urandom_range(ACT_SPARE_HI)), 1'($urandom_range(1)), $urandom);
				default: begin
					repeat ($urandom_range(6, 1))
						queue_cmd(ACT_ADD, 1'($urandom_range(1)), pick_value());
					case ($urandom_range(3))
						0: queue_cmd(ACT_DRAIN_DOG, KIND_DOG, '0);
						1: queue_cmd(ACT_DRAIN_CAT, KIND_CAT, '0);
						2: queue_cmd(ACT_QUERY, KIND_DOG, '0);
						default: queue_cmd(ACT_POLL, KIND_CAT, '0);
					endcase
				end
			endcase
		end

		// First third with rare sender idles, second third with frequent ones,
		// last third back to back.
		cmd_total = cmd_backlog.size();
		foreach (cmd_backlog[i]) begin
			if (i < cmd_total / 3)
				pct = CALM_IDLE_PCT;
			else if (i < 2 * cmd_total / 3)
				pct = HEAVY_IDLE_PCT;
			else
				pct = 0;
			while (cmd_backlog[i].gap < MAX_GAP && $urandom_range(99) < pct)
				cmd_backlog[i].gap++;
		end
	end

	// Sender. The command on the ports is taken at an edge with start high and
	// busy low. Idle cycles are counted from the edge that took the previous
	// command, so they overlap the core's busy time at random points.
	cmd_t        on_port;
	int unsigned gap_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				step_shadow_queue(on_port);
				cmds_taken++;
			end
			// The ports are free unless a command is still waiting on busy.
			if (!start || !busy) begin
				if (gap_left != 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (cmd_backlog.size() != 0) begin
					on_port = cmd_backlog.pop_front();
					action <= on_port.action;
					kind <= on_port.kind;
					value <= on_port.value;
					start <= 1'b1;
					gap_left = (cmd_backlog.size() != 0) ? cmd_backlog[0].gap : 0;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Receiver. The core cannot be stalled, so every strobe is taken and matched
	// with the oldest predicted result.
	always @(posedge clk) begin
		out_rec_t want;
		if (arst_n && strobe === 1'b1) begin
			if (awaited_out.size() == 0) begin
				$error("result with none predicted: kind_res=%0d value_res=%h is_status=%0d",
					kind_res, value_res, is_status);
				mismatches++;
			end else begin
				want = awaited_out.pop_front();
				check_field("kind_res", 32'(want.kind_res), 32'(kind_res));
				check_field("value_res", want.value_res, value_res);
				check_field("is_status", 32'(want.is_status), 32'(is_status));
				check_field("all_empty", 32'(want.all_empty), 32'(all_empty));
				check_field("dogs_empty", 32'(want.dogs_empty), 32'(dogs_empty));
				check_field("cats_empty", 32'(want.cats_empty), 32'(cats_empty));
				check_field("overflow", 32'(want.overflow), 32'(overflow));
				check_field("last", 32'(want.last), 32'(last));
			end
		end
	end

	// Reset once, wait until every command was taken and every predicted result
	// has come, then give the core a few more cycles to show any stray result.
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (cmd_total == 0 || cmds_taken < cmd_total);
		do @(posedge clk); while (awaited_out.size() != 0);
		repeat (DRAIN_OUT_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[two_class_order_queue_core] OK");
		else
			$display("[two_class_order_queue_core] ERROR");
		$finish;
	end

	// Hang guard, far beyond the slowest correct run.
	initial begin
		#(RUN_LIMIT_NS);
		$display("[two_class_order_queue_core] ERROR");
		$finish;
	end

endmodule
